@@ rtl/hwrm_pkg.sv @@
package hwrm_pkg;

    localparam int TEMP_W  = 15;
    localparam int TIME_W  = 32;
    localparam int SENS_N  = 4;

    typedef logic signed [TEMP_W-1:0] t_temp;
    typedef logic signed [TEMP_W:0]   t_temp_diff;
    typedef logic [TIME_W-1:0]        t_time;
    typedef logic [1:0]               t_sensor;

    localparam t_sensor SENSOR_TANK  = 2'd0;
    localparam t_sensor SENSOR_PIPE  = 2'd1;
    localparam t_sensor SENSOR_INLET = 2'd2;
    localparam t_sensor SENSOR_ROOM  = 2'd3;

    // register indexes on the APB port
    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_TANK_THR  = 2'd0;
    localparam t_reg_idx REG_PIPE_THR  = 2'd1;
    localparam t_reg_idx REG_DROP_GAP  = 2'd2;
    localparam t_reg_idx REG_ACT_WIN   = 2'd3;

    localparam t_temp TANK_THR_RST = 15'sd5200;
    localparam t_temp PIPE_THR_RST = 15'sd3800;
    localparam t_time DROP_GAP_RST = 32'd10000;
    localparam t_time ACT_WIN_RST  = 32'd120000;

    // hundredths of a degree
    localparam t_temp_diff MOVE_LIMIT  = 16'sd10;
    localparam t_temp_diff DROP_LIMIT  = 16'sd30;
    localparam t_temp_diff RISE_LIMIT  = 16'sd50;
    localparam t_temp_diff PIPE_HYST   = 16'sd200;

endpackage

@@ rtl/hwrm_in_if.sv @@
interface hwrm_in_if
    import hwrm_pkg::*;
();

    logic    valid;
    logic    ready;
    t_sensor sensor_index;
    t_temp   reading;
    t_time   now_ms;

    modport source (output valid, output sensor_index, output reading, output now_ms,
                    input ready);
    modport sink   (input valid, input sensor_index, input reading, input now_ms,
                    output ready);
endinterface

@@ rtl/hwrm_out_if.sv @@
interface hwrm_out_if;
    logic valid;
    logic ready;
    logic ready_res;
    logic show_status_mode;
    logic tank_falling;
    logic redraw_needed;

    modport source (output valid, output ready_res, output show_status_mode,
                    output tank_falling, output redraw_needed, input ready);
    modport sink   (input valid, input ready_res, input show_status_mode,
                    input tank_falling, input redraw_needed, output ready);
endinterface

@@ rtl/hot_water_readiness_monitor.sv @@
// Hot water readiness monitor. Each request carries one timestamped reading
// from the tank, outlet pipe, heating inlet or room sensor and yields exactly
// one result: readiness, status display mode, the tank dropping flag and a
// redraw mark. A request is captured in an input register and evaluated
// from there, once the output register can take the result, against the
// sensor state, which is updated in that same cycle; the result lands in an
// output register. A result thus passes the input and output registers, and
// one request can be taken every cycle: the rate is set by the single
// evaluation stage, and the input keeps flowing while a result waits as long
// as the output register drains. Thresholds and time windows are written
// through the APB port (0x0 tank threshold, 0x4 pipe threshold, 0x8 drop
// check gap in ms, 0xC activity window in ms) and must only be changed while
// no request is in flight. Temperatures are signed hundredths of a degree;
// time differences wrap modulo 2^32.
module hot_water_readiness_monitor
    import hwrm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    hwrm_in_if.sink     i_req,
    hwrm_out_if.source  o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration
    t_temp r_tank_thr, r_pipe_thr;
    t_time r_drop_gap, r_act_win;

    // input register
    logic    r_in_valid;
    t_sensor r_in_sel;
    t_temp   r_in_val;
    t_time   r_in_now;

    // output register
    logic r_out_valid;
    logic r_out_ready, r_out_mode, r_out_drop, r_out_redraw;

    // sensor state
    t_temp       r_tank, r_tank_prior, r_pipe, r_inlet, r_room;
    logic [3:0]  r_valid;
    logic        r_drop;
    t_time       r_last_tank, r_last_act;
    logic        r_ready, r_mode;

    t_temp       n_tank, n_tank_prior, n_pipe, n_inlet, n_room;
    logic [3:0]  n_valid;
    logic        n_drop;
    t_time       n_last_tank, n_last_act;
    logic        n_ready, n_mode, n_redraw;

    logic        fire;
    logic        in_acc;
    t_reg_idx    reg_idx;

    assign fire   = r_in_valid && (!r_out_valid || o_res.ready);
    assign in_acc = i_req.valid && i_req.ready;
    assign i_req.ready = !r_in_valid || fire;

    // ---------------------------------------------------------------- APB
    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;

    always_comb begin
        case (reg_idx)
            REG_TANK_THR: prdata = {{(32-TEMP_W){r_tank_thr[TEMP_W-1]}}, r_tank_thr};
            REG_PIPE_THR: prdata = {{(32-TEMP_W){r_pipe_thr[TEMP_W-1]}}, r_pipe_thr};
            REG_DROP_GAP: prdata = r_drop_gap;
            REG_ACT_WIN:  prdata = r_act_win;
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tank_thr <= TANK_THR_RST;
            r_pipe_thr <= PIPE_THR_RST;
            r_drop_gap <= DROP_GAP_RST;
            r_act_win  <= ACT_WIN_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                REG_TANK_THR: r_tank_thr <= pwdata[TEMP_W-1:0];
                REG_PIPE_THR: r_pipe_thr <= pwdata[TEMP_W-1:0];
                REG_DROP_GAP: r_drop_gap <= pwdata;
                REG_ACT_WIN:  r_act_win  <= pwdata;
                default:      ;
            endcase
        end
    end

    // ---------------------------------------------------------- evaluation
    t_temp      old_val;
    t_temp_diff move_d, tank_d, pipe_min;
    logic       moved, gap_over, act, mode_old;
    t_time      tank_gap, act_gap;

    always_comb begin
        case (r_in_sel)
            SENSOR_TANK:  old_val = r_tank;
            SENSOR_PIPE:  old_val = r_pipe;
            SENSOR_INLET: old_val = r_inlet;
            SENSOR_ROOM:  old_val = r_room;
            default:      old_val = r_room;
        endcase
    end

    assign move_d   = t_temp_diff'(old_val) - t_temp_diff'(r_in_val);
    assign moved    = (move_d > MOVE_LIMIT) || (move_d < -MOVE_LIMIT);
    assign tank_d   = t_temp_diff'(r_in_val) - t_temp_diff'(r_tank_prior);
    assign tank_gap = r_in_now - r_last_tank;
    assign gap_over = r_valid[SENSOR_TANK] && (tank_gap > r_drop_gap);
    assign pipe_min = t_temp_diff'(r_pipe_thr) - PIPE_HYST;
    // window test against the old activity time runs in parallel; a fresh
    // activity makes the gap zero
    assign act_gap  = r_in_now - r_last_act;
    assign mode_old = act_gap < r_act_win;

    always_comb begin
        n_tank       = r_tank;
        n_tank_prior = r_tank_prior;
        n_pipe       = r_pipe;
        n_inlet      = r_inlet;
        n_room       = r_room;
        n_valid      = r_valid;
        n_drop       = r_drop;
        n_last_tank  = r_last_tank;
        n_redraw     = moved;
        act          = 1'b0;

        case (r_in_sel)
            SENSOR_TANK: begin
                act = moved;
                if (gap_over && (tank_d < -DROP_LIMIT)) begin
                    n_drop   = 1'b1;
                    n_redraw = 1'b1;
                    act      = 1'b1;
                end else if (gap_over && (tank_d > RISE_LIMIT)) begin
                    n_drop   = 1'b0;
                    n_redraw = 1'b1;
                    act      = 1'b1;
                end
                n_tank_prior = r_tank;
                n_tank       = r_in_val;
                n_last_tank  = r_in_now;
                n_valid[SENSOR_TANK] = 1'b1;
            end
            SENSOR_PIPE: begin
                act     = moved;
                n_pipe  = r_in_val;
                n_valid[SENSOR_PIPE] = 1'b1;
            end
            SENSOR_INLET: begin
                act     = moved;
                n_inlet = r_in_val;
                n_valid[SENSOR_INLET] = 1'b1;
            end
            default: begin
                // room changes redraw but are not hot-water activity
                n_room  = r_in_val;
                n_valid[SENSOR_ROOM] = 1'b1;
            end
        endcase

        n_last_act = act ? r_in_now : r_last_act;
        n_mode     = act ? (r_act_win != '0) : mode_old;

        // readiness with hysteresis on the pipe threshold; entry also needs the tank dropping flag
        if (n_valid[SENSOR_TANK] && n_valid[SENSOR_PIPE]) begin
            if (r_ready)
                n_ready = (n_tank >= r_tank_thr) && (t_temp_diff'(n_pipe) >= pipe_min);
            else
                n_ready = (n_tank >= r_tank_thr) && n_drop && (n_pipe >= r_pipe_thr);
        end else begin
            n_ready = 1'b0;
        end

        n_redraw = n_redraw || (n_ready != r_ready) || (n_mode != r_mode);
    end

    // ---------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_sel <= i_req.sensor_index;
            r_in_val <= i_req.reading;
            r_in_now <= i_req.now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_ready  <= n_ready;
            r_out_mode   <= n_mode;
            r_out_drop   <= n_drop;
            r_out_redraw <= n_redraw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tank       <= '0;
            r_tank_prior <= '0;
            r_pipe       <= '0;
            r_inlet      <= '0;
            r_room       <= '0;
            r_valid      <= '0;
            r_drop       <= 1'b0;
            r_last_tank  <= '0;
            r_last_act   <= '0;
            r_ready      <= 1'b0;
            r_mode       <= 1'b0;
        end else if (fire) begin
            r_tank       <= n_tank;
            r_tank_prior <= n_tank_prior;
            r_pipe       <= n_pipe;
            r_inlet      <= n_inlet;
            r_room       <= n_room;
            r_valid      <= n_valid;
            r_drop       <= n_drop;
            r_last_tank  <= n_last_tank;
            r_last_act   <= n_last_act;
            r_ready      <= n_ready;
            r_mode       <= n_mode;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.ready_res        = r_out_ready;
    assign o_res.show_status_mode = r_out_mode;
    assign o_res.tank_falling     = r_out_drop;
    assign o_res.redraw_needed    = r_out_redraw;

    // ---------------------------------------------------------- checks
    a_ready_needs_sensors: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |-> (r_valid[SENSOR_TANK] && r_valid[SENSOR_PIPE]))
        else $error("ready without tank and pipe readings");

    a_ready_entry_on_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !r_ready && n_ready) |-> n_drop)
        else $error("ready entered without tank dropping");

    a_result_follows_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> (r_out_valid && (r_out_ready == r_ready) && (r_out_drop == r_drop)))
        else $error("result register out of step with state");

    a_empty_out_takes_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_req.ready)
        else $error("request stalled with empty result register");

endmodule
